// ===== design/pnlt_pkg.sv =====
// ----------------------------------------------------------------------------
// pnlt_pkg
// Shared types and constants of the packed neighbor-list table: field widths,
// action and status codes, FSM states and the control/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnlt_pkg;

  // Default sizing
  localparam int unsigned PNLT_MAX_POINTS    = 4096;
  localparam int unsigned PNLT_MAX_NEIGHBORS = 64;
  localparam int unsigned PNLT_POOL_ENTRIES  = 16384;

  // Field widths
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned PIDX_W   = 12;
  localparam int unsigned NIDX_W   = 12;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned SCNT_W   = 7;
  localparam int unsigned PCNT_W   = 13;
  localparam int unsigned PAIR_W   = NIDX_W + DIST_W;

  localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(4096);

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_PREPARE = 3'd1,
    ACT_ADD     = 3'd2,
    ACT_COMMIT  = 3'd3,
    ACT_QUERY   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_STAGE_FULL = 3'd1,
    ST_POOL_FULL  = 3'd2,
    ST_BAD_POINT  = 3'd3,
    ST_BAD_SLOT   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLEAR,
    S_COPY,
    S_COPY_END,
    S_QTBL,
    S_QPOOL
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic    latch;       // capture the input beat
    logic    clr_start;   // restart sweep counter, empty pool
    logic    sweep_step;  // zero one table entry
    logic    prep;        // select point, empty staging list
    logic    add;         // append one staging pair
    logic    copy_start;  // restart copy counter
    logic    copy_step;   // read one staging pair
    logic    commit;      // record count/start, advance tail
    logic    tbl_rd;      // read table entry of queried point
    logic    pool_rd;     // read pool pair of query
    logic    respond;     // load result registers, fire strobe
    logic    show_count;
    logic    show_data;
    status_e resp_status;
  } pnlt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             pidx_ok;
    logic             cur_ok;
    logic             stage_full;
    logic             stage_empty;
    logic             pool_fits;
    logic             slot_bad;
    logic             sweep_last;
    logic             copy_last;
  } pnlt_stat_t;

endpackage

`default_nettype wire

// ===== design/packed_neighbor_list_table.sv =====
// ----------------------------------------------------------------------------
// packed_neighbor_list_table
// Builds per-point neighbor lists in a fixed packed pool: staged adds, commit
// to the pool tail with count/start recorded per point, and pair queries.
//
//   Channel   Ports                                        Handshake
//   command   action/point_index/neighbor_index/           start_i & !busy_o
//             distance_bits/slot _i
//   result    status/neighbor_out/distance_out/            done_o, one cycle,
//             stored_count _o                              no back-pressure
//   config    cfg_data_i (point_count)                     cfg_valid_i & cfg_ready_o
//
// Per command beat: prepare, add and unused codes answer from the dispatch
// state; a query answers early on a bad point, else after the table read and,
// for a valid slot, the pool read; commit answers from dispatch when empty or
// refused, else copies one staging pair per cycle over the pool port; clear
// zeroes one table entry per cycle. After reset the same table sweep runs with
// busy_o high. The result strobe can come while the next command is accepted;
// the receiver cannot stall it. Config writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packed_neighbor_list_table #(
  parameter int unsigned MAX_POINTS    = pnlt_pkg::PNLT_MAX_POINTS,
  parameter int unsigned MAX_NEIGHBORS = pnlt_pkg::PNLT_MAX_NEIGHBORS,
  parameter int unsigned POOL_ENTRIES  = pnlt_pkg::PNLT_POOL_ENTRIES
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire [pnlt_pkg::ACT_W-1:0]    action_i,
  input  wire [pnlt_pkg::PIDX_W-1:0]   point_index_i,
  input  wire [pnlt_pkg::NIDX_W-1:0]   neighbor_index_i,
  input  wire [pnlt_pkg::DIST_W-1:0]   distance_bits_i,
  input  wire [pnlt_pkg::SLOT_W-1:0]   slot_i,
  output logic                         done_o,
  output logic [pnlt_pkg::STAT_W-1:0]  status_o,
  output logic [pnlt_pkg::NIDX_W-1:0]  neighbor_out_o,
  output logic [pnlt_pkg::DIST_W-1:0]  distance_out_o,
  output logic [pnlt_pkg::SCNT_W-1:0]  stored_count_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [pnlt_pkg::PCNT_W-1:0]   cfg_data_i
);
  import pnlt_pkg::*;

  pnlt_cmd_t  cmd;
  pnlt_stat_t stat;

  // Register write never waits
  assign cfg_ready_o = 1'b1;

  // Sequencer
  pnlt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start_i),
    .busy   (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Storage and result path
  pnlt_dpath #(
    .MAX_POINTS    (MAX_POINTS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .POOL_ENTRIES  (POOL_ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (action_i),
    .point_index_i    (point_index_i),
    .neighbor_index_i (neighbor_index_i),
    .distance_bits_i  (distance_bits_i),
    .slot_i           (slot_i),
    .cfg_valid_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .neighbor_out_o   (neighbor_out_o),
    .distance_out_o   (distance_out_o),
    .stored_count_o   (stored_count_o)
  );

endmodule

`default_nettype wire

// ===== design/pnlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnlt_ctrl
// Sequencer of the neighbor-list table: takes a command beat, steps the
// datapath through clear sweeps, staging copies and two-step table lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnlt_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start,
  output logic                   busy,
  input  pnlt_pkg::pnlt_stat_t   stat_i,
  output pnlt_pkg::pnlt_cmd_t    cmd_o
);
  import pnlt_pkg::*;

  state_e state_q, state_d;

  // State register; reset enters the table clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        unique case (stat_i.act)
          ACT_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            state_d         = S_CLEAR;
          end
          ACT_PREPARE: begin
            cmd_o.respond = 1'b1;
            if (stat_i.pidx_ok) begin
              cmd_o.prep = 1'b1;
            end else begin
              cmd_o.resp_status = ST_BAD_POINT;
            end
          end
          ACT_ADD: begin
            cmd_o.respond = 1'b1;
            if (stat_i.stage_full) begin
              cmd_o.resp_status = ST_STAGE_FULL;
            end else begin
              cmd_o.add = 1'b1;
            end
          end
          ACT_COMMIT: begin
            priority if (stat_i.stage_empty) begin
              cmd_o.respond = 1'b1;
            end else if (!stat_i.cur_ok) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = ST_BAD_POINT;
            end else if (!stat_i.pool_fits) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = ST_POOL_FULL;
            end else begin
              cmd_o.copy_start = 1'b1;
              state_d          = S_COPY;
            end
          end
          ACT_QUERY: begin
            if (stat_i.pidx_ok) begin
              cmd_o.tbl_rd = 1'b1;
              state_d      = S_QTBL;
            end else begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = ST_BAD_POINT;
            end
          end
          default: begin
            // unused action codes: plain ok beat
            cmd_o.respond = 1'b1;
          end
        endcase
      end
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (stat_i.copy_last) state_d = S_COPY_END;
      end
      S_COPY_END: begin
        // last pool write lands here together with the table update
        cmd_o.commit  = 1'b1;
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      S_QTBL: begin
        if (stat_i.slot_bad) begin
          cmd_o.respond     = 1'b1;
          cmd_o.show_count  = 1'b1;
          cmd_o.resp_status = ST_BAD_SLOT;
          state_d           = S_IDLE;
        end else begin
          cmd_o.pool_rd = 1'b1;
          state_d       = S_QPOOL;
        end
      end
      S_QPOOL: begin
        cmd_o.respond    = 1'b1;
        cmd_o.show_count = 1'b1;
        cmd_o.show_data  = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pnlt_dpath.sv =====
// ----------------------------------------------------------------------------
// pnlt_dpath
// Storage and arithmetic of the neighbor-list table: command beat registers,
// staging list, per-point table, pair pool, tail/fill counters and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnlt_dpath #(
  parameter int unsigned MAX_POINTS    = pnlt_pkg::PNLT_MAX_POINTS,
  parameter int unsigned MAX_NEIGHBORS = pnlt_pkg::PNLT_MAX_NEIGHBORS,
  parameter int unsigned POOL_ENTRIES  = pnlt_pkg::PNLT_POOL_ENTRIES
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire [pnlt_pkg::ACT_W-1:0]     action_i,
  input  wire [pnlt_pkg::PIDX_W-1:0]    point_index_i,
  input  wire [pnlt_pkg::NIDX_W-1:0]    neighbor_index_i,
  input  wire [pnlt_pkg::DIST_W-1:0]    distance_bits_i,
  input  wire [pnlt_pkg::SLOT_W-1:0]    slot_i,
  input  wire                           cfg_valid_i,
  input  wire [pnlt_pkg::PCNT_W-1:0]    cfg_data_i,
  input  pnlt_pkg::pnlt_cmd_t           cmd_i,
  output pnlt_pkg::pnlt_stat_t          stat_o,
  output logic                          done_o,
  output logic [pnlt_pkg::STAT_W-1:0]   status_o,
  output logic [pnlt_pkg::NIDX_W-1:0]   neighbor_out_o,
  output logic [pnlt_pkg::DIST_W-1:0]   distance_out_o,
  output logic [pnlt_pkg::SCNT_W-1:0]   stored_count_o
);
  import pnlt_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_NEIGHBORS + 1);            // fill / count
  localparam int unsigned SAW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned TAW = $clog2(MAX_POINTS);                   // table address
  localparam int unsigned PAW = $clog2(POOL_ENTRIES);                 // pool address
  localparam int unsigned PTW = $clog2(POOL_ENTRIES + 1);             // pool tail
  localparam int unsigned TEW = CW + PAW;                             // table entry

  // Command beat registers
  logic [ACT_W-1:0]  act_q;
  logic [PIDX_W-1:0] pidx_q;
  logic [NIDX_W-1:0] nidx_q;
  logic [DIST_W-1:0] dist_q;
  logic [SLOT_W-1:0] slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      pidx_q <= point_index_i;
      nidx_q <= neighbor_index_i;
      dist_q <= distance_bits_i;
      slot_q <= slot_i;
    end
  end

  // Control state: config, staging fill, current point, tail, counters
  logic [PCNT_W-1:0] pcnt_q;
  logic [CW-1:0]     fill_q;
  logic [PIDX_W-1:0] cur_q;
  logic [PTW-1:0]    tail_q;
  logic [TAW-1:0]    sw_q;
  logic [CW-1:0]     copy_q;
  logic              cp_wr_q;
  logic [SAW-1:0]    cp_idx_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q  <= PCNT_RESET;
      fill_q  <= '0;
      cur_q   <= '0;
      tail_q  <= '0;
      sw_q    <= '0;
      copy_q  <= '0;
      cp_wr_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) pcnt_q <= cfg_data_i;
      if (cmd_i.prep) begin
        cur_q  <= pidx_q;
        fill_q <= '0;
      end else if (cmd_i.add) begin
        fill_q <= fill_q + CW'(1);
      end
      if (cmd_i.clr_start) begin
        sw_q   <= '0;
        tail_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sw_q <= sw_q + TAW'(1);
      end else if (cmd_i.commit) begin
        tail_q <= tail_q + PTW'(fill_q);
      end
      if (cmd_i.copy_start) begin
        copy_q <= '0;
      end else if (cmd_i.copy_step) begin
        copy_q <= copy_q + CW'(1);
      end
      cp_wr_q <= cmd_i.copy_step;
      done_q  <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_idx_q <= copy_q[SAW-1:0];
  end

  // Bounds checks against min(point_count, MAX_POINTS)
  logic [31:0] pidx_w, cur_w, tail_w, fill_w;
  logic        pidx_ok, cur_ok;

  assign pidx_w  = 32'(pidx_q);
  assign cur_w   = 32'(cur_q);
  assign tail_w  = 32'(tail_q);
  assign fill_w  = 32'(fill_q);
  assign pidx_ok = (pidx_w < 32'(pcnt_q)) && (pidx_w < 32'(MAX_POINTS));
  assign cur_ok  = (cur_w < 32'(pcnt_q)) && (cur_w < 32'(MAX_POINTS));

  // Staging list: written by add, read one pair a cycle during commit
  logic [PAIR_W-1:0] stage_mem [MAX_NEIGHBORS];
  logic [PAIR_W-1:0] stage_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add && (fill_w < 32'(MAX_NEIGHBORS))) begin
      stage_mem[fill_q[SAW-1:0]] <= {nidx_q, dist_q};
    end
    if (cmd_i.copy_step) begin
      stage_rd_q <= stage_mem[copy_q[SAW-1:0]];
    end
  end

  // Per-point table {count, start}: one write port shared by sweep and commit
  logic [TEW-1:0] tbl_mem [MAX_POINTS];
  logic [TEW-1:0] tbl_rd_q;
  logic           tbl_we;
  logic [TAW-1:0] tbl_wa;
  logic [TEW-1:0] tbl_wd;
  logic [CW-1:0]  tbl_cnt;
  logic [PAW-1:0] tbl_start;

  always_comb begin
    tbl_we = cmd_i.sweep_step | cmd_i.commit;
    if (cmd_i.sweep_step) begin
      tbl_wa = sw_q;
      tbl_wd = '0;
    end else begin
      tbl_wa = cur_w[TAW-1:0];
      tbl_wd = {fill_q, tail_q[PAW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (cmd_i.tbl_rd) tbl_rd_q <= tbl_mem[pidx_w[TAW-1:0]];
  end

  assign tbl_cnt   = tbl_rd_q[TEW-1:PAW];
  assign tbl_start = tbl_rd_q[PAW-1:0];

  // Pair pool: each copy write lands in the cycle after its staging read
  logic [PAIR_W-1:0] pool_mem [POOL_ENTRIES];
  logic [PAIR_W-1:0] pool_rd_q;
  logic [PTW-1:0]    pool_wsum;
  logic [PAW-1:0]    pool_ra;

  assign pool_wsum = tail_q + PTW'(cp_idx_q);
  assign pool_ra   = tbl_start + PAW'(slot_q);

  always_ff @(posedge clk_i) begin
    if (cp_wr_q) pool_mem[pool_wsum[PAW-1:0]] <= stage_rd_q;
    if (cmd_i.pool_rd) pool_rd_q <= pool_mem[pool_ra];
  end

  // Status toward the sequencer
  always_comb begin
    stat_o             = '0;
    stat_o.act         = act_q;
    stat_o.pidx_ok     = pidx_ok;
    stat_o.cur_ok      = cur_ok;
    stat_o.stage_full  = (fill_w >= 32'(MAX_NEIGHBORS));
    stat_o.stage_empty = (fill_q == '0);
    stat_o.pool_fits   = (tail_w <= 32'(POOL_ENTRIES)) &&
                         (fill_w <= (32'(POOL_ENTRIES) - tail_w));
    stat_o.slot_bad    = (32'(slot_q) >= 32'(tbl_cnt));
    stat_o.sweep_last  = (sw_q == TAW'(MAX_POINTS - 1));
    stat_o.copy_last   = (copy_q == (fill_q - CW'(1)));
  end

  // Result registers, loaded with the strobe and held until the next result
  logic [31:0]       cnt_w;
  logic [STAT_W-1:0] status_q;
  logic [NIDX_W-1:0] nb_q;
  logic [DIST_W-1:0] dout_q;
  logic [SCNT_W-1:0] scnt_q;

  assign cnt_w = 32'(tbl_cnt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      status_q <= cmd_i.resp_status;
      scnt_q   <= cmd_i.show_count ? cnt_w[SCNT_W-1:0] : '0;
      nb_q     <= cmd_i.show_data ? pool_rd_q[PAIR_W-1:DIST_W] : '0;
      dout_q   <= cmd_i.show_data ? pool_rd_q[DIST_W-1:0] : '0;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign neighbor_out_o = nb_q;
  assign distance_out_o = dout_q;
  assign stored_count_o = scnt_q;

endmodule

`default_nettype wire
